### hw/rtl/separable_blur_5x5_defines.svh
// Assertion macros used by the checker file.
`ifndef SEPARABLE_BLUR_5X5_DEFINES_SVH
`define SEPARABLE_BLUR_5X5_DEFINES_SVH

// Same-cycle implication, muted while rst is high.
`define SB5_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sb5 same-cycle check failed");

// Next-cycle implication, muted while rst is high (pass 1'b0 to never mute).
`define SB5_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sb5 next-cycle check failed");

`endif

### hw/rtl/sb5_pkg.sv
package sb5_pkg;

   localparam int CHAN_W      = 8;
   localparam int POS_W       = 11;
   localparam int CFG_W       = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int SUM_W       = 12;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int WORD_ROWS   = 4;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [1:0]       LAST_TAP     = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // blue in the low byte, as in the line store word
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pix_type;

   localparam int PIX_W  = $bits(pix_type);
   localparam int WORD_W = WORD_ROWS * PIX_W;

   // one window row: entry 0 is column x-4, entry 4 is column x
   typedef pix_type [4:0] win_row_type;
   // window rows: entry 0 is row y-2, entry 2 is row y
   typedef win_row_type [2:0] win_type;

   // one queued input word with everything the back end needs
   typedef struct packed {
      win_type           win;
      logic [POS_W-1:0]  row_base;   // (y-2) mod 2^11
      logic [POS_W-1:0]  col_base;   // (x-2) mod 2^11
      logic [1:0]        s_lo;
      logic [1:0]        s_hi;
      logic [1:0]        j_lo;
      logic [1:0]        j_hi;
      logic              y_last;
      logic              x_last;
   } item_type;

   // floor(v/10) for v < 2560 by reciprocal multiply
   function automatic logic [CHAN_W-1:0] div10(input logic [SUM_W-1:0] v);
      logic [24:0] p;
      p = 25'(v) * 25'd6554;
      return p[23:16];
   endfunction

   // 1-2-4-2-1 weighted sum
   function automatic logic [SUM_W-1:0] wsum(input logic [CHAN_W-1:0] a, b, c, d, e);
      return 12'(a) + (12'(b) << 1) + (12'(c) << 2) + (12'(d) << 1) + 12'(e);
   endfunction

   function automatic pix_type blur5(input pix_type a, b, c, d, e);
      pix_type r;
      r.blue  = div10(wsum(a.blue,  b.blue,  c.blue,  d.blue,  e.blue));
      r.green = div10(wsum(a.green, b.green, c.green, d.green, e.green));
      r.red   = div10(wsum(a.red,   b.red,   c.red,   d.red,   e.red));
      return r;
   endfunction

endpackage

### hw/rtl/sb5_chan_if.sv
interface sb5_req_if;
   logic                       valid;
   logic                       ready;
   logic [sb5_pkg::CHAN_W-1:0] in_blue;
   logic [sb5_pkg::CHAN_W-1:0] in_green;
   logic [sb5_pkg::CHAN_W-1:0] in_red;

   modport source (output valid, in_blue, in_green, in_red, input ready);
   modport sink   (input valid, in_blue, in_green, in_red, output ready);
endinterface

interface sb5_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [sb5_pkg::POS_W-1:0]  out_row;
   logic [sb5_pkg::POS_W-1:0]  out_col;
   logic [sb5_pkg::CHAN_W-1:0] out_blue;
   logic [sb5_pkg::CHAN_W-1:0] out_green;
   logic [sb5_pkg::CHAN_W-1:0] out_red;
   logic                       run_last;
   logic                       frame_done;

   modport source (output valid, out_row, out_col, out_blue, out_green, out_red,
                   run_last, frame_done, input ready);
   modport sink   (input valid, out_row, out_col, out_blue, out_green, out_red,
                   run_last, frame_done, output ready);
endinterface

### hw/rtl/sb5_ram.sv
module sb5_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### hw/rtl/sb5_front.sv
module sb5_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                            clock,
   input  logic                            reset,
   sb5_req_if.sink                         req_chan,
   input  logic                            csr_we,
   input  logic [sb5_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sb5_pkg::CFG_W-1:0]       csr_wdata,
   input  logic [sb5_pkg::QCNT_W-1:0]      q_count,
   output logic                            push_v,
   output sb5_pkg::item_type               push_item
);
   import sb5_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   // configuration and position counters
   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [XW-1:0]    x_ff, x_in, wm1;
   logic [YW-1:0]    y_ff, y_in, hm1;
   logic             accept, restart;
   logic [QCNT_W:0]  occ;

   // stage 1: line store read data arrives
   logic            s1_v_ff;
   pix_type         s1_pix_ff;
   logic [XW-1:0]   s1_x_ff;
   logic [YW-1:0]   s1_y_ff;
   logic            s1_xl_ff, s1_yl_ff;
   logic [WORD_W-1:0] rd_data, word, new_word;
   logic            wr_v_ff;
   logic [XW-1:0]   wr_addr_ff;
   logic [WORD_W-1:0] wr_data_ff;
   pix_type         t0, t1, t2, t3;
   pix_type [2:0]   vsum;

   // stage 2: vertical results into the windows
   logic            s2_v_ff;
   pix_type [2:0]   s2_vs_ff;
   logic [XW-1:0]   s2_x_ff;
   logic [YW-1:0]   s2_y_ff;
   logic            s2_xl_ff, s2_yl_ff;
   win_type         win_ff, win_in;

   // clamp sizes to 1..MAX, kept as size minus one
   always_comb begin
      if (width_ff == '0) begin
         wm1 = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         wm1 = XW'(MAX_WIDTH - 1);
      end else begin
         wm1 = XW'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         hm1 = '0;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         hm1 = YW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = YW'(height_ff - 1'b1);
      end
   end

   // take a word only if the queue has room for everything in flight
   assign occ            = {1'b0, q_count} + (QCNT_W+1)'(s1_v_ff) + (QCNT_W+1)'(s2_v_ff);
   assign req_chan.ready = occ < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept         = req_chan.valid & req_chan.ready;
   assign restart        = csr_we && (csr_index == CSR_IMAGE_WIDTH ||
                                      csr_index == CSR_IMAGE_HEIGHT);

   // register writes and raster counters
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      if (csr_we && csr_index == CSR_IMAGE_WIDTH) begin
         width_in = csr_wdata;
      end
      if (csr_we && csr_index == CSR_IMAGE_HEIGHT) begin
         height_in = csr_wdata;
      end
      if (restart) begin
         x_in = '0;
         y_in = '0;
      end else if (accept) begin
         if (x_ff == wm1) begin
            x_in = '0;
            y_in = (y_ff == hm1) ? '0 : y_ff + 1'b1;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         x_ff      <= '0;
         y_ff      <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         wr_v_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         s1_v_ff   <= accept;
         s2_v_ff   <= s1_v_ff;
         wr_v_ff   <= s1_v_ff;
      end
   end

   // line store: one word per column holds rows y-1..y-4
   sb5_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (s1_v_ff),
      .waddr (s1_x_ff),
      .wdata (new_word),
      .raddr (x_ff),
      .rdata (rd_data)
   );

   // forward last cycle's write when it hit the column just read
   assign word     = (wr_v_ff && wr_addr_ff == s1_x_ff) ? wr_data_ff : rd_data;
   assign new_word = {word[WORD_W-PIX_W-1:0], s1_pix_ff};

   // rows above the frame top read as zero
   always_comb begin
      t3 = (s1_y_ff >= YW'(1)) ? pix_type'(word[PIX_W-1:0])         : '0;
      t2 = (s1_y_ff >= YW'(2)) ? pix_type'(word[2*PIX_W-1:PIX_W])   : '0;
      t1 = (s1_y_ff >= YW'(3)) ? pix_type'(word[3*PIX_W-1:2*PIX_W]) : '0;
      t0 = (s1_y_ff >= YW'(4)) ? pix_type'(word[4*PIX_W-1:3*PIX_W]) : '0;
      vsum[0] = blur5(t0, t1, t2, t3, s1_pix_ff);
      vsum[1] = blur5(t1, t2, t3, s1_pix_ff, '0);
      vsum[2] = blur5(t2, t3, s1_pix_ff, '0, '0);
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      s1_pix_ff  <= '{red: req_chan.in_red, green: req_chan.in_green,
                      blue: req_chan.in_blue};
      s1_x_ff    <= x_ff;
      s1_y_ff    <= y_ff;
      s1_xl_ff   <= (x_ff == wm1);
      s1_yl_ff   <= (y_ff == hm1);
      wr_addr_ff <= s1_x_ff;
      wr_data_ff <= new_word;
      s2_vs_ff   <= vsum;
      s2_x_ff    <= s1_x_ff;
      s2_y_ff    <= s1_y_ff;
      s2_xl_ff   <= s1_xl_ff;
      s2_yl_ff   <= s1_yl_ff;
      win_ff     <= win_in;
   end

   // shift windows; a new row starts from zeros
   always_comb begin
      win_in = win_ff;
      if (s2_v_ff) begin
         for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < 4; k++) begin
               win_in[s][k] = (s2_x_ff == '0) ? '0 : win_ff[s][k+1];
            end
            win_in[s][4] = s2_vs_ff[s];
         end
      end
   end

   // queue only words that complete at least one output
   always_comb begin
      push_v = s2_v_ff && (s2_y_ff >= YW'(2) || s2_yl_ff)
                       && (s2_x_ff >= XW'(2) || s2_xl_ff);
      push_item.win      = win_in;
      push_item.row_base = POS_W'(s2_y_ff) - POS_W'(2);
      push_item.col_base = POS_W'(s2_x_ff) - POS_W'(2);
      push_item.s_lo     = (s2_y_ff >= YW'(2)) ? 2'd0 : ((s2_y_ff == YW'(1)) ? 2'd1 : 2'd2);
      push_item.s_hi     = s2_yl_ff ? LAST_TAP : 2'd0;
      push_item.j_lo     = (s2_x_ff >= XW'(2)) ? 2'd0 : ((s2_x_ff == XW'(1)) ? 2'd1 : 2'd2);
      push_item.j_hi     = s2_xl_ff ? LAST_TAP : 2'd0;
      push_item.y_last   = s2_yl_ff;
      push_item.x_last   = s2_xl_ff;
   end
endmodule

### hw/rtl/sb5_queue.sv
module sb5_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_v,
   input  sb5_pkg::item_type          push_item,
   input  logic                       pop,
   output logic                       head_v,
   output sb5_pkg::item_type          head,
   output logic [sb5_pkg::QCNT_W-1:0] count
);
   import sb5_pkg::*;

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wp_ff, rp_ff;
   logic [QCNT_W-1:0]  cnt_ff;

   assign head_v = (cnt_ff != '0);
   assign head   = slot_ff[rp_ff];
   assign count  = cnt_ff;

   // pointers and fill count; the front never pushes into a full queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_v) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + QCNT_W'(push_v) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_v) begin
         slot_ff[wp_ff] <= push_item;
      end
   end
endmodule

### hw/rtl/sb5_back.sv
module sb5_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_v,
   input  sb5_pkg::item_type head,
   output logic              pop,
   sb5_rsp_if.source         rsp_chan
);
   import sb5_pkg::*;

   logic [1:0]        ds_ff, ds_in, dj_ff, dj_in, s, j;
   logic              load, last_s, last_j;
   logic              out_v_ff, out_v_in;
   win_row_type       wrow;
   pix_type           hsum;
   logic [POS_W-1:0]  row_ff, col_ff;
   pix_type           pix_ff;
   logic              run_last_ff, frame_done_ff;

   // output register frees when empty or taken
   assign load   = head_v && (!out_v_ff || rsp_chan.ready);
   assign s      = head.s_lo + ds_ff;
   assign j      = head.j_lo + dj_ff;
   assign last_s = (s == head.s_hi);
   assign last_j = (j == head.j_hi);
   assign pop    = load && last_s && last_j;
   assign wrow   = head.win[s];

   // horizontal pass for the selected column offset
   always_comb begin
      case (j)
         2'd0:    hsum = blur5(wrow[0], wrow[1], wrow[2], wrow[3], wrow[4]);
         2'd1:    hsum = blur5(wrow[1], wrow[2], wrow[3], wrow[4], '0);
         default: hsum = blur5(wrow[2], wrow[3], wrow[4], '0, '0);
      endcase
   end

   // walk rows outer, columns inner
   always_comb begin
      ds_in    = ds_ff;
      dj_in    = dj_ff;
      out_v_in = out_v_ff;
      if (load) begin
         out_v_in = 1'b1;
         if (last_j) begin
            dj_in = '0;
            ds_in = last_s ? 2'd0 : ds_ff + 1'b1;
         end else begin
            dj_in = dj_ff + 1'b1;
         end
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff    <= '0;
         dj_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         ds_ff    <= ds_in;
         dj_ff    <= dj_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff        <= head.row_base + POS_W'(s);
         col_ff        <= head.col_base + POS_W'(j);
         pix_ff        <= hsum;
         run_last_ff   <= last_s && last_j;
         frame_done_ff <= head.y_last && head.x_last && s == LAST_TAP && j == LAST_TAP;
      end
   end

   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.out_row    = row_ff;
   assign rsp_chan.out_col    = col_ff;
   assign rsp_chan.out_blue   = pix_ff.blue;
   assign rsp_chan.out_green  = pix_ff.green;
   assign rsp_chan.out_red    = pix_ff.red;
   assign rsp_chan.run_last   = run_last_ff;
   assign rsp_chan.frame_done = frame_done_ff;
endmodule

### hw/rtl/separable_blur_5x5.sv
// Channel   Dir  Handshake     Word
// req_chan  in   valid/ready   in_blue, in_green, in_red (one pixel, raster order)
// rsp_chan  out  valid/ready   out_row, out_col, out_blue/green/red, run_last, frame_done
// csr_*     in   csr_we        csr_index, csr_wdata (image_width, image_height)
//
// One pixel per cycle in while the queue has room; the back end emits one result per
// cycle while rsp_chan is ready, so a word that completes n results (up to 9 at the
// frame's bottom-right corner) holds the back end until all n are out, and the
// 4-entry queue then backs up the input. An input reaches its first result through the
// line store read, vertical stage, window stage and output register. Reset is synchronous
// and needs no clearing pass. Either side may stall at any time without loss.
module separable_blur_5x5 #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   sb5_req_if.sink                       req_chan,
   sb5_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [sb5_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sb5_pkg::CFG_W-1:0]     csr_wdata
);
   import sb5_pkg::*;

   logic              push_v, pop, head_v;
   item_type          push_item, head;
   logic [QCNT_W-1:0] q_count;

   sb5_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .push_v    (push_v),
      .push_item (push_item)
   );

   sb5_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_v    (push_v),
      .push_item (push_item),
      .pop       (pop),
      .head_v    (head_v),
      .head      (head),
      .count     (q_count)
   );

   sb5_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_v   (head_v),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule

### hw/rtl/sb5_checker.sv
`include "separable_blur_5x5_defines.svh"

module sb5_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sb5_pkg::POS_W-1:0]  rsp_out_row,
   input logic [sb5_pkg::POS_W-1:0]  rsp_out_col,
   input logic                       rsp_run_last,
   input logic                       rsp_frame_done
);
   // no result right after reset
   `SB5_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   // the frame's last pixel closes its word's run
   `SB5_ASSERT_IMP(a_done_is_last, clock, reset, rsp_valid && rsp_frame_done, rsp_run_last)
   // a stalled result keeps its position
   `SB5_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_row) && $stable(rsp_out_col))
endmodule

bind separable_blur_5x5 sb5_checker u_sb5_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_out_row    (rsp_chan.out_row),
   .rsp_out_col    (rsp_chan.out_col),
   .rsp_run_last   (rsp_chan.run_last),
   .rsp_frame_done (rsp_chan.frame_done)
);

### tb/sv/tb_separable_blur_5x5.sv
module tb_separable_blur_5x5;
   import sb5_pkg::*;

   localparam int LINE_MAX  = 2048;
   localparam int ROW_MAX   = 2048;
   localparam int WDOG_MAX  = 20000;
   localparam int SETTLE    = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
      logic              last;
      logic              done;
   } blur_pix_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   sb5_req_if req ();
   sb5_rsp_if rsp ();

   separable_blur_5x5 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // stimulus queue and expected blurred pixels
   pix_type       pixel_queue[$];
   blur_pix_type  blurred_queue[$];
   idle_mode_type idle_mode;
   logic          req_fire;
   int            mismatches;
   int            stall_count;

   // predictor state
   logic [CFG_W-1:0]  width_reg;
   logic [CFG_W-1:0]  height_reg;
   logic [PIX_W-1:0]  line_mem[4][LINE_MAX];
   int                next_row;
   int                next_col;
   logic [CHAN_W-1:0] vwin[3][5][3];

   function automatic int clamp_dim(input int v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int tap_wt(input int m);
      return (m == 0) ? 4 : ((m == 1 || m == -1) ? 2 : 1);
   endfunction

   function automatic void restart_frame();
      next_row = 0;
      next_col = 0;
      for (int s = 0; s < 3; s++)
         for (int k = 0; k < 5; k++)
            for (int ch = 0; ch < 3; ch++) vwin[s][k][ch] = '0;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
      if (idx == CSR_IMAGE_WIDTH) begin
         width_reg = val;
         restart_frame();
      end else if (idx == CSR_IMAGE_HEIGHT) begin
         height_reg = val;
         restart_frame();
      end
   endfunction

   // blur every output pixel that this input completes
   function automatic void predict_blur(input pix_type px);
      int w, h, y, x, q, sum, k, rlo, rhi, clo, chi, s, first;
      int taps[5][3];
      logic [PIX_W-1:0] wd;
      blur_pix_type o;
      w = clamp_dim(width_reg, LINE_MAX);
      h = clamp_dim(height_reg, ROW_MAX);
      if (next_row >= h || next_col >= w) restart_frame();
      y = next_row;
      x = next_col;
      // column taps from rows y-4..y-1, then the new pixel
      for (int d = 0; d < 4; d++) begin
         q = y - 4 + d;
         wd = (q >= 0) ? line_mem[q & 3][x] : '0;
         for (int ch = 0; ch < 3; ch++) taps[d][ch] = wd[8*ch +: 8];
      end
      taps[4][0] = px.blue;
      taps[4][1] = px.green;
      taps[4][2] = px.red;
      line_mem[y & 3][x] = px;
      // vertical pass into the row windows
      for (s = 0; s < 3; s++) begin
         if (x == 0)
            for (int kk = 0; kk < 5; kk++)
               for (int ch = 0; ch < 3; ch++) vwin[s][kk][ch] = '0;
         for (int kk = 0; kk < 4; kk++) vwin[s][kk] = vwin[s][kk+1];
         for (int ch = 0; ch < 3; ch++) begin
            sum = 0;
            for (int m = -2; m <= 2; m++) begin
               q = y - 2 + s + m;
               if (q < 0 || q > y || q >= h) continue;
               sum += taps[q - (y - 4)][ch] * tap_wt(m);
            end
            vwin[s][4][ch] = 8'(sum / 10);
         end
      end
      if (y == h - 1) begin
         rlo = (y >= 2) ? y - 2 : 0; rhi = y;
      end else if (y >= 2) begin
         rlo = y - 2; rhi = y - 2;
      end else begin
         rlo = 0; rhi = -1;
      end
      if (x == w - 1) begin
         clo = (x >= 2) ? x - 2 : 0; chi = x;
      end else if (x >= 2) begin
         clo = x - 2; chi = x - 2;
      end else begin
         clo = 0; chi = -1;
      end
      first = blurred_queue.size();
      for (int r = rlo; r <= rhi; r++) begin
         s = r - (y - 2);
         for (int c = clo; c <= chi; c++) begin
            int ov[3];
            for (int ch = 0; ch < 3; ch++) begin
               sum = 0;
               for (int m = -2; m <= 2; m++) begin
                  k = c + m - (x - 4);
                  if (c + m < 0 || c + m >= w || k < 0 || k > 4) continue;
                  sum += vwin[s][k][ch] * tap_wt(m);
               end
               ov[ch] = sum / 10;
            end
            o.row = 11'(r); o.col = 11'(c);
            o.blue = 8'(ov[0]); o.green = 8'(ov[1]); o.red = 8'(ov[2]);
            o.last = 1'b0;
            o.done = (r == h - 1 && c == w - 1);
            blurred_queue.push_back(o);
         end
      end
      if (blurred_queue.size() > first) blurred_queue[$].last = 1'b1;
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
         if (next_row >= h) next_row = 0;
      end
   endfunction

   function automatic logic idle_roll(input logic sender);
      case (idle_mode)
         IDLE_SEND: return sender && ($urandom_range(99) < 88);
         IDLE_RECV: return !sender && ($urandom_range(99) < 88);
         IDLE_BOTH: return $urandom_range(99) < 25;
         default:   return 1'b0;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // driver: change inputs on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !idle_roll(1'b0);
         if (!req.valid || req_fire) begin
            if (pixel_queue.size() > 0 && !idle_roll(1'b1)) begin
               pix_type px;
               px = pixel_queue.pop_front();
               req.in_blue  <= px.blue;
               req.in_green <= px.green;
               req.in_red   <= px.red;
               req.valid    <= 1'b1;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: sample on the rising edge, predict and check
   always @(posedge clock) begin
      req_fire <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready) begin
            pix_type px;
            px.blue = req.in_blue; px.green = req.in_green; px.red = req.in_red;
            predict_blur(px);
         end
         if (rsp.valid && rsp.ready) begin
            if (blurred_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word row=%0d col=%0d",
                     rsp.out_row, rsp.out_col);
            end else begin
               blur_pix_type e;
               e = blurred_queue.pop_front();
               if (rsp.out_row !== e.row || rsp.out_col !== e.col ||
                   rsp.out_blue !== e.blue || rsp.out_green !== e.green ||
                   rsp.out_red !== e.red || rsp.run_last !== e.last ||
                   rsp.frame_done !== e.done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("exp %0d,%0d %0d/%0d/%0d %0b%0b got %0d,%0d %0d/%0d/%0d %0b%0b",
                        e.row, e.col, e.blue, e.green, e.red, e.last, e.done,
                        rsp.out_row, rsp.out_col, rsp.out_blue, rsp.out_green,
                        rsp.out_red, rsp.run_last, rsp.frame_done);
               end
            end
         end
         // watchdog on cycles without any accepted word
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_count <= 0;
         else stall_count <= stall_count + 1;
         if (stall_count >= WDOG_MAX) begin
            $display("tb_separable_blur_5x5: FAIL");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_queue.size() != 0 || req.valid || blurred_queue.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_csr(idx, val);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic push_random(input int n);
      pix_type px;
      for (int i = 0; i < n; i++) begin
         px.blue  = 8'($urandom);
         px.green = 8'($urandom);
         px.red   = 8'($urandom);
         pixel_queue.push_back(px);
      end
   endtask

   task automatic set_size(input int w, input int h);
      wait_drained();
      csr_write(CSR_IMAGE_WIDTH, 12'(w));
      csr_write(CSR_IMAGE_HEIGHT, 12'(h));
   endtask

   initial begin
      pix_type px;
      reset      = 1'b1;
      req.valid  = 1'b0;
      req.in_blue = '0; req.in_green = '0; req.in_red = '0;
      rsp.ready  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_IMAGE_WIDTH;
      csr_wdata  = '0;
      req_fire   = 1'b0;
      mismatches = 0;
      stall_count = 0;
      idle_mode  = IDLE_NONE;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      restart_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset size: first row of a large frame makes no results
      push_random(4);

      // 3x3 frame of extremes: corner pixel completes nine results
      set_size(3, 3);
      for (int i = 0; i < 9; i++) begin
         px.blue  = (i % 2) ? 8'hff : 8'h00;
         px.green = (i % 3) ? 8'h00 : 8'hff;
         px.red   = 8'hff;
         pixel_queue.push_back(px);
      end
      push_random(9);

      // zero sizes act as one; unused register index is ignored
      set_size(0, 0);
      csr_write(CSR_UNUSED, 12'hfff);
      push_random(3);

      // oversize width clamps to the maximum, single-row frame
      set_size(4095, 1);
      push_random(8);
      // oversize height, two columns
      set_size(2, 4095);
      push_random(8);

      // random frames under each idling pattern
      set_size(7, 5);
      idle_mode = IDLE_SEND;
      push_random(20);
      set_size(5, 9);
      idle_mode = IDLE_RECV;
      push_random(9);
      // hold the sender until everything queued has come back
      wait_drained();
      push_random(9);
      set_size(6, 4);
      idle_mode = IDLE_BOTH;
      push_random(24);
      set_size(4, 3);
      idle_mode = IDLE_NONE;
      push_random(12);

      wait_drained();
      if (mismatches == 0 && blurred_queue.size() == 0) begin
         $display("tb_separable_blur_5x5: PASS");
      end else begin
         $display("tb_separable_blur_5x5: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sb5_pkg.sv
hw/rtl/sb5_chan_if.sv
hw/rtl/sb5_ram.sv
hw/rtl/sb5_front.sv
hw/rtl/sb5_queue.sv
hw/rtl/sb5_back.sv
hw/rtl/separable_blur_5x5.sv
hw/rtl/sb5_checker.sv
tb/sv/tb_separable_blur_5x5.sv
